// File: hdl/kmp_pkg.sv
// Package for the KMP stream matcher: beat payload types, FSM states and
// the function and error codes shared by the controller and the top level.
// Depends on nothing.
package kmp_pkg;

	localparam int PAT_MAX_DEF = 64;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_SAT   = 2'd2;
	localparam logic [1:0] ERR_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       first;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        matched;
		logic [31:0] match_pos;
		logic        no_match;
		logic [6:0]  prefix_len;
		logic [1:0]  error;
	} result_t;

endpackage

// File: hdl/kmp_chan_if.sv
// Valid/ready channel interface used for the item and result streams.
// The payload type is set by the instantiating module (types from kmp_pkg).
interface kmp_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/kmp_tables.sv
// Pattern store and failure table: two synchronous memories with one write
// port and one registered read port each. Uses kmp_pkg for the default depth.
module kmp_tables #(
	parameter int PAT_MAX = kmp_pkg::PAT_MAX_DEF,
	localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    pat_rd,
	output logic [AW-1:0] fail_rd,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_pat,
	input  logic [AW-1:0] wr_fail
);

	logic [7:0]    pat_mem [PAT_MAX];
	logic [AW-1:0] fail_mem [PAT_MAX];
	logic [AW-1:0] fail_addr;
	logic [7:0]    pat_rd_q;
	logic [AW-1:0] fail_rd_q;

	// The failure entry of the previous position is fetched with the byte,
	// so one read step yields both the compare byte and the fallback length.
	assign fail_addr = (rd_addr == '0) ? '0 : rd_addr - AW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem[wr_addr]  <= wr_pat;
			fail_mem[wr_addr] <= wr_fail;
		end
		if (rd_en) begin
			pat_rd_q  <= pat_mem[rd_addr];
			fail_rd_q <= fail_mem[fail_addr];
		end
	end

	assign pat_rd  = pat_rd_q;
	assign fail_rd = fail_rd_q;

endmodule

// File: hdl/kmp_walk_ctrl.sv
// Sequencer of the KMP matcher: accepts an item, walks the failure chain
// through kmp_tables one probe per cycle, updates the match state and hands
// a finished result to the output register. Uses kmp_pkg.
module kmp_walk_ctrl #(
	parameter int PAT_MAX = kmp_pkg::PAT_MAX_DEF,
	localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1,
	localparam int PW = $clog2(PAT_MAX + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kmp_pkg::item_t    in_data,
	input  logic              slot_free,
	output logic              fin,
	output kmp_pkg::result_t  res,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [7:0]        pat_rd,
	input  logic [AW-1:0]     fail_rd,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [7:0]        wr_pat,
	output logic [AW-1:0]     wr_fail
);

	kmp_pkg::state_t state_q, state_nxt;

	logic [PW-1:0] pattern_len_q;
	logic [AW-1:0] build_prefix_q;
	logic [PW-1:0] match_prefix_q;
	logic [31:0]   text_index_q;
	logic          found_q;

	kmp_pkg::item_t item_q;
	logic [PW-1:0]  q_q;

	logic          accept;
	logic [PW-1:0] a_plen;
	logic [PW-1:0] a_mp;
	logic          a_found;
	logic          a_walk;
	logic [PW-1:0] a_q;

	logic          pat_hit;
	logic          walk_done;
	logic [PW-1:0] q_res;
	logic [PW-1:0] q_fin;

	logic [PW-1:0] f_plen;
	logic [AW-1:0] f_bp;
	logic [PW-1:0] f_mp;
	logic [31:0]   f_ti;
	logic          f_found;
	logic          f_full;
	logic          f_sat;
	logic [PW-1:0] f_plen_out;
	logic [31:0]   plen_wide;

	logic [PW-1:0] n_pattern_len;
	logic [AW-1:0] n_build_prefix;
	logic [PW-1:0] n_match_prefix;
	logic [31:0]   n_text_index;
	logic          n_found;

	assign accept = in_valid && in_ready;

	// Start of an item, evaluated on the incoming beat.
	always_comb begin
		a_plen  = in_data.first ? '0 : pattern_len_q;
		a_mp    = in_data.first ? '0 : match_prefix_q;
		a_found = in_data.first ? 1'b0 : found_q;
		if (in_data.func == kmp_pkg::FUNC_PATTERN) begin
			a_walk = (a_plen != '0) && (a_plen != PW'(PAT_MAX));
			a_q    = in_data.first ? '0 : PW'(build_prefix_q);
		end else begin
			a_walk = (pattern_len_q != '0) && !a_found;
			a_q    = a_mp;
		end
	end

	// One probe of the failure chain: compare the fetched byte.
	assign pat_hit   = (pat_rd == item_q.data_byte);
	assign walk_done = pat_hit || (q_q == '0);
	assign q_res     = pat_hit ? q_q + PW'(1) : q_q;
	assign q_fin     = (state_q == kmp_pkg::ST_WALK) ? q_res : q_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kmp_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = a_walk ? kmp_pkg::ST_WALK : kmp_pkg::ST_FIN;
				end
			end
			kmp_pkg::ST_WALK: begin
				if (walk_done) begin
					state_nxt = slot_free ? kmp_pkg::ST_IDLE : kmp_pkg::ST_FIN;
				end
			end
			kmp_pkg::ST_FIN: begin
				if (slot_free) begin
					state_nxt = kmp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = kmp_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		in_ready = 1'b0;
		fin      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = fail_rd;
		unique case (state_q)
			kmp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = accept && a_walk;
				rd_addr  = a_q[AW-1:0];
			end
			kmp_pkg::ST_WALK: begin
				fin   = walk_done && slot_free;
				rd_en = !walk_done;
			end
			kmp_pkg::ST_FIN: begin
				fin = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Completion of an item from the latched beat and the walk result.
	always_comb begin
		f_plen  = item_q.first ? '0 : pattern_len_q;
		f_bp    = item_q.first ? '0 : build_prefix_q;
		f_mp    = item_q.first ? '0 : match_prefix_q;
		f_ti    = item_q.first ? '0 : text_index_q;
		f_found = item_q.first ? 1'b0 : found_q;
		f_full  = (f_plen == PW'(PAT_MAX));
		f_sat   = &f_ti;

		res            = '0;
		f_plen_out     = '0;
		wr_en          = 1'b0;
		wr_addr        = f_plen[AW-1:0];
		wr_pat         = item_q.data_byte;
		wr_fail        = (f_plen == '0) ? '0 : q_fin[AW-1:0];
		n_pattern_len  = pattern_len_q;
		n_build_prefix = build_prefix_q;
		n_match_prefix = '0;
		n_text_index   = '0;
		n_found        = 1'b0;

		if (item_q.func == kmp_pkg::FUNC_PATTERN) begin
			if (f_full) begin
				res.error      = kmp_pkg::ERR_FULL;
				n_pattern_len  = f_plen;
				n_build_prefix = f_bp;
				f_plen_out     = f_plen;
			end else begin
				wr_en          = fin;
				n_pattern_len  = f_plen + PW'(1);
				n_build_prefix = wr_fail;
				f_plen_out     = f_plen + PW'(1);
			end
		end else begin
			n_match_prefix = f_mp;
			n_found        = f_found;
			n_text_index   = f_sat ? f_ti : f_ti + 32'd1;
			if (f_sat) begin
				res.error = kmp_pkg::ERR_SAT;
			end
			if (pattern_len_q == '0) begin
				res.error    = kmp_pkg::ERR_EMPTY;
				res.no_match = item_q.last_byte;
			end else if (f_found) begin
				f_plen_out = pattern_len_q;
			end else begin
				n_match_prefix = q_fin;
				f_plen_out     = q_fin;
				if (q_fin == pattern_len_q) begin
					n_found       = 1'b1;
					res.matched   = 1'b1;
					res.match_pos = f_ti - 32'(pattern_len_q) + 32'd1;
				end else begin
					res.no_match = item_q.last_byte;
				end
			end
			if (item_q.last_byte) begin
				n_match_prefix = '0;
				n_text_index   = '0;
				n_found        = 1'b0;
			end
		end

		plen_wide      = 32'(f_plen_out);
		res.prefix_len = plen_wide[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= kmp_pkg::ST_IDLE;
			pattern_len_q  <= '0;
			build_prefix_q <= '0;
			match_prefix_q <= '0;
			text_index_q   <= '0;
			found_q        <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fin) begin
				pattern_len_q  <= n_pattern_len;
				build_prefix_q <= n_build_prefix;
				match_prefix_q <= n_match_prefix;
				text_index_q   <= n_text_index;
				found_q        <= n_found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			q_q    <= a_q;
		end else if (state_q == kmp_pkg::ST_WALK) begin
			q_q <= walk_done ? q_res : PW'(fail_rd);
		end
	end

`ifndef SYNTHESIS
	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> slot_free)
		else $error("result finished while the output register is occupied");

	a_chain_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmp_pkg::ST_WALK && !walk_done) |=> (q_q < $past(q_q)))
		else $error("failure chain step did not shorten the prefix");

	a_text_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmp_pkg::ST_WALK && item_q.func == kmp_pkg::FUNC_TEXT)
		|-> (q_q < pattern_len_q))
		else $error("text probe beyond the loaded pattern");

	a_build_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmp_pkg::ST_WALK && item_q.func == kmp_pkg::FUNC_PATTERN)
		|-> (q_q < f_plen))
		else $error("pattern probe beyond the stored bytes");

	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (match_prefix_q == pattern_len_q))
		else $error("found flag set without a full-length prefix");
`endif

endmodule

// File: hdl/kmp_stream_matcher.sv
// Top level of the KMP stream matcher: channel interfaces, output register,
// sequencer and table memories. Uses kmp_pkg, kmp_chan_if, kmp_tables and
// kmp_walk_ctrl.
//
//  Channel  Modport  Payload            Beat meaning
//  -------  -------  -----------------  ----------------------------------
//  item     sink     kmp_pkg::item_t    one pattern byte or one text byte
//  result   source   kmp_pkg::result_t  one result for each item beat
//
// An item beat is accepted in ST_IDLE and then walks the failure chain in
// ST_WALK, one failure-chain probe after another; items that need no walk go
// straight to ST_FIN. Each probe is one read of the pattern and failure
// memories, so the single read port sets the rate; the chain amortizes to at
// most two probes per text byte.
// Reset clears the FSM, the pattern length and all text progress; the memories
// are not cleared, since only entries below the loaded length are ever read.
// A stalled result stays in the output register; the next item is still
// taken, and only its completion waits for the register to drain.
module kmp_stream_matcher #(
	parameter int PAT_MAX = kmp_pkg::PAT_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	kmp_chan_if.sink   item,
	kmp_chan_if.source result
);

	localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

	logic              fin;
	logic              slot_free;
	kmp_pkg::result_t  res;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        pat_rd;
	logic [AW-1:0]     fail_rd;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [7:0]        wr_pat;
	logic [AW-1:0]     wr_fail;

	logic              out_valid_q;
	kmp_pkg::result_t  out_data_q;

	// The output register can take a new result when it is empty or when its
	// current beat leaves in this same cycle.
	assign slot_free = !out_valid_q || result.ready;

	kmp_walk_ctrl #(
		.PAT_MAX(PAT_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_data  (item.data),
		.slot_free(slot_free),
		.fin      (fin),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.pat_rd   (pat_rd),
		.fail_rd  (fail_rd),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_pat   (wr_pat),
		.wr_fail  (wr_fail)
	);

	kmp_tables #(
		.PAT_MAX(PAT_MAX)
	) u_tables (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.pat_rd (pat_rd),
		.fail_rd(fail_rd),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_pat (wr_pat),
		.wr_fail(wr_fail)
	);

	// Output register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

// File: dv/kmp_stream_matcher_tb.sv
// Self-checking testbench for kmp_stream_matcher: a queue-fed driver, a result
// monitor and a bit-accurate matcher prediction with its own state.
// Depends on kmp_pkg, kmp_chan_if and the kmp_stream_matcher RTL.
module kmp_stream_matcher_tb;

	localparam int PAT_MAX     = kmp_pkg::PAT_MAX_DEF;
	localparam int RANDOM_N    = 650;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 5000;
	localparam int TAIL_CYCLES = 2 * PAT_MAX + 16;

	typedef struct {
		kmp_pkg::item_t it;
		int             gap;
		bit             drain;
	} stim_t;

	bit   clk;
	logic arst_n;

	kmp_chan_if #(.payload_t(kmp_pkg::item_t))   item_ch ();
	kmp_chan_if #(.payload_t(kmp_pkg::result_t)) result_ch ();

	kmp_stream_matcher #(.PAT_MAX(PAT_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stimulus and scoreboard state.
	stim_t            stim_q[$];
	kmp_pkg::result_t expected_q[$];
	int               n_pushed;
	int               fail_count;
	int               results_seen;
	int               idle_cycles;
	bit               drain_next;
	bit               send_burst;
	bit               item_fire;
	bit               res_fire;

	// Generator copy of the pattern just loaded, used to plant matches in text.
	bit [7:0] gen_pat[80];
	int       gen_len;
	bit [7:0] alpha[4];
	int       alpha_n;

	// Predicted matcher state.
	bit [7:0]    pat_mem[PAT_MAX];
	bit [5:0]    fail_mem[PAT_MAX];
	int unsigned pat_len;
	int unsigned build_k;
	int unsigned match_q;
	bit [31:0]   text_pos;
	bit          found_flag;

	function automatic void restart_text();
		match_q    = 0;
		text_pos   = '0;
		found_flag = 1'b0;
	endfunction

	// Follow the failure chain from prefix length q until byte b extends it.
	function automatic int unsigned chain_walk(int unsigned q, bit [7:0] b);
		while (q > 0 && q < PAT_MAX && pat_mem[q] != b)
			q = fail_mem[q - 1];
		if (q < PAT_MAX && pat_mem[q] == b)
			q++;
		return q;
	endfunction

	function automatic kmp_pkg::result_t predict_match(kmp_pkg::item_t it);
		kmp_pkg::result_t r;
		int unsigned      q;
		bit [31:0]        here;
		r = '0;
		if (it.func == kmp_pkg::FUNC_PATTERN) begin
			if (it.first) begin
				pat_len = 0;
				build_k = 0;
			end
			restart_text();
			if (pat_len >= PAT_MAX) begin
				r.error = kmp_pkg::ERR_FULL;
			end else begin
				q = pat_len;
				pat_mem[q] = it.data_byte;
				if (q == 0) begin
					fail_mem[0] = '0;
					build_k = 0;
				end else begin
					build_k = chain_walk(build_k, it.data_byte);
					fail_mem[q] = 6'(build_k);
				end
				pat_len = q + 1;
			end
			r.prefix_len = 7'(pat_len);
		end else begin
			if (it.first)
				restart_text();
			here = text_pos;
			if (here == 32'hFFFF_FFFF)
				r.error = kmp_pkg::ERR_SAT;
			else
				text_pos = here + 32'd1;
			if (pat_len == 0) begin
				r.error    = kmp_pkg::ERR_EMPTY;
				r.no_match = it.last_byte;
			end else if (found_flag) begin
				r.prefix_len = 7'(pat_len);
			end else begin
				q = chain_walk(match_q, it.data_byte);
				if (q >= pat_len) begin
					q          = pat_len;
					found_flag = 1'b1;
					r.matched  = 1'b1;
					r.match_pos = here - 32'(pat_len) + 32'd1;
				end else if (it.last_byte) begin
					r.no_match = 1'b1;
				end
				match_q = q;
				r.prefix_len = 7'(q);
			end
			if (it.last_byte)
				restart_text();
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic push_item(input logic f, input logic [7:0] b, input logic fst,
			input logic lst);
		stim_t s;
		s.it.func      = f;
		s.it.data_byte = b;
		s.it.first     = fst;
		s.it.last_byte = lst;
		// Flip between back-to-back bursts and random gaps now and then.
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		s.gap   = send_burst ? 0 : $urandom_range(0, 6);
		s.drain = drain_next;
		drain_next = 1'b0;
		stim_q.push_back(s);
		n_pushed++;
	endtask

	// Loads a pattern over a fresh small alphabet; usually starts a new pattern.
	task automatic make_pattern(input int len);
		bit [7:0] b;
		alpha_n = $urandom_range(1, 4);
		for (int i = 0; i < 4; i++)
			alpha[i] = 8'($urandom_range(0, 255));
		gen_len = len;
		for (int i = 0; i < len; i++) begin
			b = alpha[$urandom_range(0, alpha_n - 1)];
			gen_pat[i] = b;
			push_item(kmp_pkg::FUNC_PATTERN, b,
				i == 0 ? ($urandom_range(0, 6) != 0) : 1'b0,
				1'($urandom_range(0, 1)));
		end
	endtask

	// Sends one text; optionally plants a copy of the pattern and closes it.
	task automatic send_text(input int len, input bit plant, input bit close);
		int       off;
		int       plen;
		bit [7:0] b;
		plen = (gen_len > PAT_MAX) ? PAT_MAX : gen_len;
		off  = plant ? $urandom_range(0, len - plen) : 0;
		for (int i = 0; i < len; i++) begin
			if (plant && i >= off && i < off + plen)
				b = gen_pat[i - off];
			else if ($urandom_range(0, 9) == 0)
				b = 8'($urandom_range(0, 255));
			else
				b = alpha[$urandom_range(0, alpha_n - 1)];
			push_item(kmp_pkg::FUNC_TEXT, b, i == 0, close && i == len - 1);
		end
	endtask

	// Monitor: predicts on every item beat and checks every result beat.
	always @(posedge clk) begin
		kmp_pkg::result_t want;
		if (!arst_n) begin
			item_fire   <= 1'b0;
			res_fire    <= 1'b0;
			idle_cycles = 0;
		end else begin
			item_fire <= item_ch.valid && item_ch.ready;
			res_fire  <= result_ch.valid && result_ch.ready;
			if (item_ch.valid && item_ch.ready)
				expected_q.push_back(predict_match(item_ch.data));
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("result beat with no expected result pending");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("matched", 32'(want.matched),
						32'(result_ch.data.matched));
					check_field("match_pos", want.match_pos, result_ch.data.match_pos);
					check_field("no_match", 32'(want.no_match),
						32'(result_ch.data.no_match));
					check_field("prefix_len", 32'(want.prefix_len),
						32'(result_ch.data.prefix_len));
					check_field("error", 32'(want.error), 32'(result_ch.data.error));
				end
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Driver: pops pending items, honors their gaps and drain requests.
	stim_t cur;
	bit    drv_fetched;
	bit    drv_offer;
	int    gap_left;

	always @(negedge clk) begin
		logic nv;
		if (!arst_n) begin
			drv_fetched = 1'b0;
			drv_offer   = 1'b0;
			item_ch.valid <= 1'b0;
		end else begin
			nv = item_ch.valid;
			if (drv_offer && item_fire) begin
				drv_offer = 1'b0;
				nv = 1'b0;
			end
			if (!drv_offer && !drv_fetched && stim_q.size() > 0) begin
				cur = stim_q.pop_front();
				gap_left = cur.gap;
				drv_fetched = 1'b1;
			end
			// A drain item waits until every earlier beat has its result back.
			if (drv_fetched && !(cur.drain && expected_q.size() != 0)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					item_ch.data <= cur.it;
					nv = 1'b1;
					drv_offer   = 1'b1;
					drv_fetched = 1'b0;
				end
			end
			item_ch.valid <= nv;
		end
	end

	// Result sink: random ready gaps, bursts, and one long hold-off that lets
	// the block back up and stall its item channel.
	int rcv_wait;
	bit rcv_burst;
	bit hold_done;
	int hold_left;

	always @(negedge clk) begin
		if (!arst_n) begin
			rcv_wait = $urandom_range(0, 6);
			result_ch.ready <= 1'b0;
		end else begin
			if (res_fire) begin
				if ($urandom_range(0, 29) == 0)
					rcv_burst = !rcv_burst;
				rcv_wait = rcv_burst ? 0 : $urandom_range(0, 6);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (rcv_wait > 0) begin
				rcv_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int kind;
		int tlen;
		int plen;
		int last_drain;
		bit plant;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		arst_n          = 1'b0;

		// Text before any pattern exists: the empty pattern never matches.
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b1, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b1);
		push_item(kmp_pkg::FUNC_TEXT, 8'h5A, 1'b1, 1'b1);
		// Pattern 00 FF 00, then a text with a false start and a late match.
		push_item(kmp_pkg::FUNC_PATTERN, 8'h00, 1'b1, 1'b1);
		push_item(kmp_pkg::FUNC_PATTERN, 8'hFF, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_PATTERN, 8'h00, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b1, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0);
		// Bytes after the match report nothing more, even on the last byte.
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b1);
		// A text that ends without a match.
		push_item(kmp_pkg::FUNC_TEXT, 8'h11, 1'b1, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h22, 1'b0, 1'b1);
		// Text resumes without a first flag, then a pattern byte is appended.
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_PATTERN, 8'h01, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b1, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hFF, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'h01, 1'b0, 1'b1);
		// Single-byte pattern and single-byte texts.
		push_item(kmp_pkg::FUNC_PATTERN, 8'hA5, 1'b1, 1'b0);
		push_item(kmp_pkg::FUNC_TEXT, 8'hA5, 1'b1, 1'b1);
		push_item(kmp_pkg::FUNC_TEXT, 8'h7E, 1'b0, 1'b1);

		// Overfill the pattern store once so that extra bytes are dropped.
		drain_next = 1'b1;
		last_drain = n_pushed;
		make_pattern(PAT_MAX + 2);
		alpha_n = 1;
		send_text(PAT_MAX + 4, 1'b1, 1'b1);
		send_text(20, 1'b0, 1'b1);

		while (n_pushed < 25 + RANDOM_N) begin
			if (n_pushed - last_drain >= 150) begin
				drain_next = 1'b1;
				last_drain = n_pushed;
			end
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				repeat ($urandom_range(1, 4))
					push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				if (kind < 50) begin
					plen = ($urandom_range(0, 11) == 0) ? $urandom_range(56, 68)
						: $urandom_range(1, 6);
					make_pattern(plen);
				end
				repeat ($urandom_range(1, 3)) begin
					plant = 1'($urandom_range(0, 1));
					tlen = $urandom_range(1, 24);
					if (plant)
						tlen = ((gen_len > PAT_MAX) ? PAT_MAX : gen_len)
							+ $urandom_range(0, 12);
					send_text(tlen, plant, $urandom_range(0, 4) != 0);
				end
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Run until every item is sent and answered, or nothing moves for too long.
		@(negedge clk);
		while (!(stim_q.size() == 0 && !drv_fetched && !drv_offer && expected_q.size() == 0)
				&& idle_cycles < IDLE_LIMIT)
			@(negedge clk);

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("kmp_stream_matcher_tb: FAIL");
		end else begin
			// Quiet tail to catch any stray result beats.
			repeat (TAIL_CYCLES) @(negedge clk);
			if (fail_count == 0 && expected_q.size() == 0) begin
				$display("kmp_stream_matcher_tb: PASS");
			end else begin
				$display("kmp_stream_matcher_tb: FAIL");
			end
		end
		$finish;
	end

endmodule

// File: files.f
hdl/kmp_pkg.sv
hdl/kmp_chan_if.sv
hdl/kmp_tables.sv
hdl/kmp_walk_ctrl.sv
hdl/kmp_stream_matcher.sv
dv/kmp_stream_matcher_tb.sv
